// ===== sv/g128_pkg.sv =====
// shared types and constants for the grain-128aead engine
package g128_pkg;

  localparam logic [2:0] ACT_START = 3'd0;
  localparam logic [2:0] ACT_AUTH  = 3'd1;
  localparam logic [2:0] ACT_ENC   = 3'd2;
  localparam logic [2:0] ACT_DEC   = 3'd3;
  localparam logic [2:0] ACT_TAG   = 3'd4;

  localparam logic [1:0] CFG_KEY_HIGH   = 2'd0;
  localparam logic [1:0] CFG_KEY_LOW    = 2'd1;
  localparam logic [1:0] CFG_NONCE_HIGH = 2'd2;
  localparam logic [1:0] CFG_NONCE_LOW  = 2'd3;

  localparam logic [31:0] IV_PAD = 32'hFFFFFFFE;

  // datapath operation codes
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_LOAD  = 3'd1;
  localparam logic [2:0] OP_INIT  = 3'd2;
  localparam logic [2:0] OP_KEY   = 3'd3;
  localparam logic [2:0] OP_ACC   = 3'd4;
  localparam logic [2:0] OP_SREG  = 3'd5;
  localparam logic [2:0] OP_KS    = 3'd6;

  typedef struct packed {
    logic [2:0] op;
    logic       absorb;
    logic       finish;
    logic       capture;
    logic       clr_pos;
  } g128_cmd_t;

  typedef struct packed {
    logic       buf_empty;
    logic       absorb_done;
  } g128_sts_t;

  function automatic logic [63:0] rev_in_bytes(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 8; j++) begin
        r[8*i+j] = v[8*i+7-j];
      end
    end
    return r;
  endfunction

endpackage

// ===== sv/g128_datapath.sv =====
// cipher state, keystream buffer and authenticator
module g128_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  g128_pkg::g128_cmd_t  cmd,
  output g128_pkg::g128_sts_t  sts,
  input  logic [6:0]           step,
  input  logic [63:0]          key_high,
  input  logic [63:0]          key_low,
  input  logic [31:0]          nonce_high,
  input  logic [63:0]          nonce_low,
  input  logic [2:0]           action,
  input  logic [7:0]           data_byte,
  output logic [7:0]           out_byte,
  output logic [63:0]          tag_value
);

  logic [127:0] lfsr, lfsr_next;
  logic [127:0] nfsr, nfsr_next;
  logic [63:0]  acc;
  logic [63:0]  sreg;
  logic [7:0]   ks_enc [8];
  logic [7:0]   ks_auth [8];
  logic [4:0]   pos;
  logic [7:0]   kenc, kauth, msg;
  logic [7:0]   msg_r, kauth_r;
  logic [3:0]   bit_cnt;
  logic [127:0] keyr;
  logic [31:0]  y;
  logic [63:0]  nh_rev, nlh_rev, nll_rev;

  assign keyr = {g128_pkg::rev_in_bytes(key_high), g128_pkg::rev_in_bytes(key_low)};
  assign nh_rev  = g128_pkg::rev_in_bytes({32'd0, nonce_high});
  assign nlh_rev = g128_pkg::rev_in_bytes({32'd0, nonce_low[63:32]});
  assign nll_rev = g128_pkg::rev_in_bytes({32'd0, nonce_low[31:0]});

  // bit i of the spec sits at vector bit 127-i
  function automatic logic tp(input logic [127:0] r, input int i);
    return r[127-i];
  endfunction

  // 32 rounds per cycle, each round only sees taps ahead of the fresh bits
  always_comb begin
    logic [127:0] s, b;
    logic yo, fl, fn, xl, xn;
    s = lfsr;
    b = nfsr;
    y = '0;
    for (int k = 0; k < 32; k++) begin
      yo = (tp(b,12) & tp(s,8)) ^ (tp(s,13) & tp(s,20)) ^ (tp(b,95) & tp(s,42))
         ^ (tp(s,60) & tp(s,79)) ^ (tp(b,12) & tp(b,95) & tp(s,94)) ^ tp(s,93)
         ^ tp(b,2) ^ tp(b,15) ^ tp(b,36) ^ tp(b,45) ^ tp(b,64) ^ tp(b,73) ^ tp(b,89);
      y[k] = yo;
      xl = 1'b0;
      xn = 1'b0;
      if (cmd.op == g128_pkg::OP_INIT) begin
        xl = yo;
        xn = yo;
      end else if (cmd.op == g128_pkg::OP_KEY) begin
        xl = yo ^ keyr[7'(63 - 32*step[0] - k)];
        xn = yo ^ keyr[7'(127 - 32*step[0] - k)];
      end
      fl = tp(s,0) ^ tp(s,7) ^ tp(s,38) ^ tp(s,70) ^ tp(s,81) ^ tp(s,96) ^ xl;
      fn = tp(s,0) ^ tp(b,0) ^ tp(b,26) ^ tp(b,56) ^ tp(b,91) ^ tp(b,96)
         ^ (tp(b,3) & tp(b,67)) ^ (tp(b,11) & tp(b,13)) ^ (tp(b,17) & tp(b,18))
         ^ (tp(b,27) & tp(b,59)) ^ (tp(b,40) & tp(b,48)) ^ (tp(b,61) & tp(b,65))
         ^ (tp(b,68) & tp(b,84)) ^ (tp(b,22) & tp(b,24) & tp(b,25))
         ^ (tp(b,70) & tp(b,78) & tp(b,82))
         ^ (tp(b,88) & tp(b,92) & tp(b,93) & tp(b,95)) ^ xn;
      s = {s[126:0], fl};
      b = {b[126:0], fn};
    end
    lfsr_next = s;
    nfsr_next = b;
  end

  assign kenc  = ks_enc[pos[3:1]];
  assign kauth = ks_auth[pos[3:1]];
  assign msg   = (action == g128_pkg::ACT_DEC) ? (data_byte ^ kenc) : data_byte;
  assign sts.buf_empty   = pos[4];
  assign sts.absorb_done = (bit_cnt == 4'd8);

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= '0;
      nfsr <= '0;
      acc <= '0;
      sreg <= '0;
      pos <= 5'd16;
      bit_cnt <= 4'd8;
      out_byte <= '0;
      tag_value <= '0;
    end else begin
      unique case (cmd.op) inside
        g128_pkg::OP_LOAD: begin
          nfsr <= keyr;
          lfsr <= {nh_rev[31:0], nlh_rev[31:0], nll_rev[31:0], g128_pkg::IV_PAD};
        end
        g128_pkg::OP_INIT, g128_pkg::OP_KEY: begin
          lfsr <= lfsr_next;
          nfsr <= nfsr_next;
        end
        g128_pkg::OP_ACC, g128_pkg::OP_SREG: begin
          lfsr <= lfsr_next;
          nfsr <= nfsr_next;
          for (int k = 0; k < 32; k++) begin
            if (cmd.op == g128_pkg::OP_ACC) begin
              if (step[0]) acc[31-k] <= y[k];
              else         acc[63-k] <= y[k];
            end else begin
              if (step[0]) sreg[31-k] <= y[k];
              else         sreg[63-k] <= y[k];
            end
          end
        end
        g128_pkg::OP_KS: begin
          lfsr <= lfsr_next;
          nfsr <= nfsr_next;
          for (int j = 0; j < 2; j++) begin
            for (int q = 0; q < 8; q++) begin
              ks_enc[{step[1:0], j[0]}][q]  <= y[16*j+2*q];
              ks_auth[{step[1:0], j[0]}][q] <= y[16*j+2*q+1];
            end
          end
        end
        default: ;
      endcase
      if (cmd.clr_pos) pos <= '0;
      if (cmd.capture) begin
        out_byte <= (action == g128_pkg::ACT_ENC || action == g128_pkg::ACT_DEC)
                    ? (data_byte ^ kenc) : 8'd0;
        tag_value <= '0;
        msg_r <= msg;
        kauth_r <= kauth;
        pos <= pos + 5'd2;
        bit_cnt <= '0;
      end
      // one message bit per cycle, lsb first
      if (cmd.absorb && bit_cnt != 4'd8) begin
        if (msg_r[bit_cnt[2:0]]) acc <= acc ^ sreg;
        sreg <= {sreg[62:0], kauth_r[bit_cnt[2:0]]};
        bit_cnt <= bit_cnt + 4'd1;
      end
      if (cmd.finish) begin
        acc <= acc ^ sreg;
        tag_value <= g128_pkg::rev_in_bytes(acc ^ sreg);
        out_byte <= '0;
      end
      if (cmd.op == g128_pkg::OP_LOAD) pos <= 5'd16;
    end
  end

endmodule

// ===== sv/g128_ctrl.sv =====
// sequencing of start, refill, byte and finish beats
module g128_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_fire,
  input  logic [2:0]           action,
  input  logic                 out_free,
  output logic                 in_ready,
  output logic                 res_load,
  output logic                 res_tag,
  output logic [6:0]           step,
  output g128_pkg::g128_cmd_t  cmd,
  input  g128_pkg::g128_sts_t  sts
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RUN   = 3'd1;
  localparam logic [2:0] S_FILL  = 3'd2;
  localparam logic [2:0] S_BYTE  = 3'd3;
  localparam logic [2:0] S_ABS   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state;
  logic [2:0] act;
  logic [4:0] rnd;   // 32-round chunks of start: 10 init, 2 key, 2 acc, 2 sreg

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    step = {2'd0, rnd};
    res_load = 1'b0;
    res_tag = 1'b0;
    unique case (state)
      S_IDLE: if (in_fire && action == g128_pkg::ACT_START) cmd.op = g128_pkg::OP_LOAD;
      S_RUN: begin
        if (rnd < 5'd10) cmd.op = g128_pkg::OP_INIT;
        else if (rnd < 5'd12) cmd.op = g128_pkg::OP_KEY;
        else if (rnd < 5'd14) cmd.op = g128_pkg::OP_ACC;
        else cmd.op = g128_pkg::OP_SREG;
        step = {2'd0, rnd - 5'd10};
      end
      S_FILL: begin
        cmd.op = g128_pkg::OP_KS;
        if (rnd == 5'd3) cmd.clr_pos = 1'b1;
      end
      S_BYTE: cmd.capture = 1'b1;
      S_ABS:  cmd.absorb = 1'b1;
      // wait here until the output register is free
      S_DONE: if (out_free) begin
        if (act == g128_pkg::ACT_TAG) cmd.finish = 1'b1;
        res_load = 1'b1;
        res_tag = (act == g128_pkg::ACT_TAG);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rnd <= '0;
      act <= g128_pkg::ACT_START;
    end else begin
      unique case (state)
        S_IDLE: if (in_fire) begin
          act <= action;
          rnd <= '0;
          case (action) inside
            g128_pkg::ACT_START: state <= S_RUN;
            g128_pkg::ACT_AUTH, g128_pkg::ACT_ENC, g128_pkg::ACT_DEC:
              state <= sts.buf_empty ? S_FILL : S_BYTE;
            default: state <= S_DONE;
          endcase
        end
        S_RUN: begin
          rnd <= rnd + 5'd1;
          if (rnd == 5'd15) state <= S_DONE;
        end
        S_FILL: begin
          rnd <= rnd + 5'd1;
          if (rnd == 5'd3) state <= S_BYTE;
        end
        S_BYTE: state <= S_ABS;
        S_ABS:  if (sts.absorb_done) state <= S_DONE;
        S_DONE: if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) state == S_BYTE |=> state == S_ABS)
    else $error("byte capture not followed by absorb");
  assert property (@(posedge clk) disable iff (rst) in_ready |-> state == S_IDLE)
    else $error("ready outside idle");
  assert property (@(posedge clk) disable iff (rst) res_load |=> state == S_IDLE)
    else $error("result not closing the item");

endmodule

// ===== sv/grain128_aead_engine_unit.sv =====
// top level of the grain-128aead engine
// cfg_we/cfg_index/cfg_data write key_high, key_low, nonce_high and nonce_low
// (index 0..3) while nothing is in flight; they take effect at the next start
// s_axis beats carry action and data_byte; every input beat gives exactly one
// m_axis beat with out_byte and tag_value on tdata and tag_valid on tuser
// from the accept edge to m_axis_tvalid: a start loads the state, then runs
// its init, key, acc and sreg rounds; a byte beat is set mostly by the
// bit-serial absorb of the authenticator (a capture step, then the absorb
// steps), plus a refill when the 16-byte keystream buffer is empty; finish or
// an unknown action goes straight to its done state
// one item is in flight at a time: the next beat is taken once the item has
// handed its result on, so a new byte beat waits until the last one is through
// the output register parts the two sides: an item may be accepted while an
// old result waits, and a finished item holds in its done state until the
// output register is free
// reset clears the cipher state to zero and empties the keystream buffer
// a stalled receiver holds m_axis_tdata and in time stalls the input
module grain128_aead_engine_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [15:0]  s_axis_tdata,   // action[2:0], data_byte[10:3], zero pad
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [71:0]  m_axis_tdata,   // out_byte[7:0], tag_value[71:8]
  output logic         m_axis_tuser    // tag_valid
);

  logic [63:0] key_high, key_low, nonce_low;
  logic [31:0] nonce_high;
  logic [2:0]  act_r;
  logic [7:0]  byte_r;
  logic        in_fire, in_ready, res_load, res_tag;
  logic [6:0]  step;
  logic [7:0]  dp_byte;
  logic [63:0] dp_tag;
  g128_pkg::g128_cmd_t cmd;
  g128_pkg::g128_sts_t sts;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = in_ready;

  // result register loads from the datapath in the cycle after the done state
  logic res_pend, res_tag_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low <= '0;
      nonce_high <= '0;
      nonce_low <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          g128_pkg::CFG_KEY_HIGH:   key_high <= cfg_data;
          g128_pkg::CFG_KEY_LOW:    key_low <= cfg_data;
          g128_pkg::CFG_NONCE_HIGH: nonce_high <= cfg_data[31:0];
          g128_pkg::CFG_NONCE_LOW:  nonce_low <= cfg_data;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if (res_pend) m_axis_tvalid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r <= s_axis_tdata[2:0];
      byte_r <= s_axis_tdata[10:3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) res_pend <= 1'b0;
    else res_pend <= res_load;
    res_tag_r <= res_tag;
  end

  always_ff @(posedge clk) begin
    if (res_pend) begin
      m_axis_tdata <= {dp_tag & {64{res_tag_r}},
                       (act_r == g128_pkg::ACT_ENC || act_r == g128_pkg::ACT_DEC)
                       ? dp_byte : 8'd0};
      m_axis_tuser <= res_tag_r;
    end
  end

  g128_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .action(s_axis_tdata[2:0]),
    .out_free(!m_axis_tvalid && !res_pend),
    .in_ready(in_ready), .res_load(res_load), .res_tag(res_tag),
    .step(step), .cmd(cmd), .sts(sts)
  );

  g128_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .step(step),
    .key_high(key_high), .key_low(key_low), .nonce_high(nonce_high),
    .nonce_low(nonce_low), .action(act_r), .data_byte(byte_r),
    .out_byte(dp_byte), .tag_value(dp_tag)
  );

endmodule

// ===== tb/g128_checker.sv =====
// checker for the grain-128aead engine: tracks the cipher state and compares every result beat
module g128_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [71:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [63:0] tag_value;
    logic        tag_valid;
  } engine_result_t;

  logic [63:0] key_hi, key_lo, nonce_hi, nonce_lo;
  // bit i of each register sits at position 127 - i
  logic [127:0] lfsr, nfsr;
  logic [63:0]  acc, sreg;
  logic [31:0]  ks_words [4];
  int unsigned  ks_pos;
  engine_result_t result_q[$];

  assign pending = result_q.size();

  function automatic logic [63:0] byte_bitrev(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[(i / 8) * 8 + 7 - (i % 8)] = v[i];
    return r;
  endfunction

  function automatic logic tp(input logic [127:0] r, input int i);
    return r[127 - i];
  endfunction

  function automatic logic cipher_preout();
    logic x0, x4;
    x0 = tp(nfsr, 12);
    x4 = tp(nfsr, 95);
    return (x0 & tp(lfsr, 8)) ^ (tp(lfsr, 13) & tp(lfsr, 20)) ^ (x4 & tp(lfsr, 42))
      ^ (tp(lfsr, 60) & tp(lfsr, 79)) ^ (x0 & x4 & tp(lfsr, 94)) ^ tp(lfsr, 93)
      ^ tp(nfsr, 2) ^ tp(nfsr, 15) ^ tp(nfsr, 36) ^ tp(nfsr, 45)
      ^ tp(nfsr, 64) ^ tp(nfsr, 73) ^ tp(nfsr, 89);
  endfunction

  task automatic cipher_clock(input logic xl, input logic xn);
    logic fl, fn;
    logic [127:0] b;
    b = nfsr;
    fl = tp(lfsr, 0) ^ tp(lfsr, 7) ^ tp(lfsr, 38) ^ tp(lfsr, 70) ^ tp(lfsr, 81)
      ^ tp(lfsr, 96) ^ xl;
    fn = tp(lfsr, 0) ^ tp(b, 0) ^ tp(b, 26) ^ tp(b, 56) ^ tp(b, 91) ^ tp(b, 96)
      ^ (tp(b, 3) & tp(b, 67)) ^ (tp(b, 11) & tp(b, 13)) ^ (tp(b, 17) & tp(b, 18))
      ^ (tp(b, 27) & tp(b, 59)) ^ (tp(b, 40) & tp(b, 48)) ^ (tp(b, 61) & tp(b, 65))
      ^ (tp(b, 68) & tp(b, 84)) ^ (tp(b, 22) & tp(b, 24) & tp(b, 25))
      ^ (tp(b, 70) & tp(b, 78) & tp(b, 82))
      ^ (tp(b, 88) & tp(b, 92) & tp(b, 93) & tp(b, 95)) ^ xn;
    lfsr = {lfsr[126:0], fl};
    nfsr = {nfsr[126:0], fn};
  endtask

  task automatic cipher_start();
    logic [127:0] keyr;
    logic [63:0] nh_rev, nlh_rev, nll_rev;
    logic y;
    keyr = {byte_bitrev(key_hi), byte_bitrev(key_lo)};
    nfsr = keyr;
    nh_rev  = byte_bitrev({32'd0, nonce_hi[31:0]});
    nlh_rev = byte_bitrev({32'd0, nonce_lo[63:32]});
    nll_rev = byte_bitrev({32'd0, nonce_lo[31:0]});
    lfsr = {nh_rev[31:0], nlh_rev[31:0], nll_rev[31:0], g128_pkg::IV_PAD};
    for (int t = 0; t < 320; t++) begin
      y = cipher_preout();
      cipher_clock(y, y);
    end
    for (int t = 0; t < 64; t++) begin
      y = cipher_preout();
      cipher_clock(y ^ tp(keyr, 64 + t), y ^ tp(keyr, t));
    end
    for (int t = 0; t < 64; t++) begin
      acc = {acc[62:0], cipher_preout()};
      cipher_clock(1'b0, 1'b0);
    end
    for (int t = 0; t < 64; t++) begin
      sreg = {sreg[62:0], cipher_preout()};
      cipher_clock(1'b0, 1'b0);
    end
    ks_pos = 16;
  endtask

  // each word carries two pairs of cipher byte (low) and shift byte (high)
  task automatic keystream_refill();
    logic [31:0] w;
    int pos;
    for (int k = 0; k < 4; k++) begin
      w = '0;
      for (int t = 0; t < 32; t++) begin
        pos = 16 * (t / 16) + ((t % 2) ? 8 : 0) + ((t % 16) / 2);
        w[pos] = cipher_preout();
        cipher_clock(1'b0, 1'b0);
      end
      ks_words[k] = w;
    end
    ks_pos = 0;
  endtask

  task automatic predict_item(input logic [2:0] act, input logic [7:0] din,
                              output engine_result_t r);
    int p;
    logic [7:0] kenc, kauth, msg;
    r = '0;
    case (act) inside
      g128_pkg::ACT_START: cipher_start();
      g128_pkg::ACT_AUTH, g128_pkg::ACT_ENC, g128_pkg::ACT_DEC: begin
        if (ks_pos >= 16) keystream_refill();
        p = (ks_pos / 2) % 8;
        kenc  = ks_words[p / 2][(p % 2) * 16 +: 8];
        kauth = ks_words[p / 2][(p % 2) * 16 + 8 +: 8];
        ks_pos += 2;
        msg = din;
        if (act == g128_pkg::ACT_ENC) r.out_byte = din ^ kenc;
        else if (act == g128_pkg::ACT_DEC) begin
          msg = din ^ kenc;
          r.out_byte = msg;
        end
        for (int b = 0; b < 8; b++) begin
          if (msg[b]) acc ^= sreg;
          sreg = {sreg[62:0], kauth[b]};
        end
      end
      g128_pkg::ACT_TAG: begin
        acc ^= sreg;
        r.tag_value = byte_bitrev(acc);
        r.tag_valid = 1'b1;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    engine_result_t e, got;
    if (rst) begin
      key_hi = '0; key_lo = '0; nonce_hi = '0; nonce_lo = '0;
      lfsr = '0; nfsr = '0; acc = '0; sreg = '0;
      ks_pos = 16;
      result_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          g128_pkg::CFG_KEY_HIGH:   key_hi = cfg_data;
          g128_pkg::CFG_KEY_LOW:    key_lo = cfg_data;
          g128_pkg::CFG_NONCE_HIGH: nonce_hi = {32'd0, cfg_data[31:0]};
          g128_pkg::CFG_NONCE_LOW:  nonce_lo = cfg_data;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.out_byte  = m_axis_tdata[7:0];
        got.tag_value = m_axis_tdata[71:8];
        got.tag_valid = m_axis_tuser;
        if (result_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count++;
        end else begin
          e = result_q.pop_front();
          if (got.out_byte !== e.out_byte) begin
            $error("out_byte expected %h actual %h", e.out_byte, got.out_byte);
            fail_count++;
          end
          if (got.tag_value !== e.tag_value) begin
            $error("tag_value expected %h actual %h", e.tag_value, got.tag_value);
            fail_count++;
          end
          if (got.tag_valid !== e.tag_valid) begin
            $error("tag_valid expected %b actual %b", e.tag_valid, got.tag_valid);
            fail_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_item(s_axis_tdata[2:0], s_axis_tdata[10:3], e);
        result_q.push_back(e);
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// stimulus and verdict for the grain-128aead engine
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tuser;
  int          fail_count, pending;
  int          tx_idle = 22, rx_idle = 52;
  int          phase = 0;
  int          sent = 0;

  always #5 clk = ~clk;

  grain128_aead_engine_unit DUT (.*);

  g128_checker u_checker (.*);

  // receiver: random stalls, plus one long hold-off at the start of the last phase
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held = 0;
    forever begin
      @(negedge clk);
      if (phase == 2 && !held) begin
        held = 1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  // tready only moves at the rising edge, so it is looked at on the falling one
  task automatic send_beat(input logic [2:0] act, input logic [7:0] din);
    while ($urandom_range(99) < tx_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, din, act};
    while (!s_axis_tready) @(negedge clk);
    @(negedge clk);
    sent++;
  endtask

  // quiet the input, drain every result and let the engine settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_keys(input logic [63:0] kh, input logic [63:0] kl,
                            input logic [63:0] nh, input logic [63:0] nl);
    logic [63:0] v [4];
    v = '{kh, kl, nh, nl};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[1:0];
      cfg_data  <= v[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [2:0] rand_byte_act();
    case ($urandom_range(2))
      0: return g128_pkg::ACT_AUTH;
      1: return g128_pkg::ACT_ENC;
      default: return g128_pkg::ACT_DEC;
    endcase
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  initial begin
    int n, target;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // bytes and finish on the all-zero state, then unknown actions, then a start, a byte and a finish
    send_beat(g128_pkg::ACT_AUTH, 8'hA5);
    send_beat(g128_pkg::ACT_ENC, 8'h00);
    send_beat(g128_pkg::ACT_DEC, 8'hFF);
    send_beat(g128_pkg::ACT_TAG, 8'h00);
    send_beat(3'd5, 8'hFF);
    send_beat(3'd6, 8'h5A);
    send_beat(3'd7, 8'h00);
    send_beat(g128_pkg::ACT_START, 8'h00);
    send_beat(g128_pkg::ACT_ENC, 8'h3C);
    send_beat(g128_pkg::ACT_TAG, 8'h00);
    drain();
    write_keys('1, '1, '1, '1);
    send_beat(g128_pkg::ACT_START, 8'hFF);
    send_beat(g128_pkg::ACT_AUTH, 8'hFF);
    send_beat(g128_pkg::ACT_ENC, 8'hFF);
    send_beat(g128_pkg::ACT_DEC, 8'h00);
    for (int i = 0; i < 6; i++) send_beat(rand_byte_act(), rand_byte());
    send_beat(g128_pkg::ACT_TAG, 8'h00);
    // repeated finish xors the shift register in again
    send_beat(g128_pkg::ACT_TAG, 8'hFF);

    for (int ph = 0; ph < 3; ph++) begin
      drain();
      phase = ph;
      if (ph == 0) begin
        tx_idle = 22; rx_idle = 52;
        write_keys(rand64(), rand64(), rand64(), rand64());
      end else if (ph == 1) begin
        tx_idle = 52; rx_idle = 22;
        write_keys('0, '0, '0, '0);
      end else begin
        tx_idle = 0; rx_idle = 0;
        write_keys(rand64(), '1, rand64(), '0);
      end
      target = sent + 130;
      while (sent < target) begin
        send_beat(g128_pkg::ACT_START, rand_byte());
        n = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 12);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(9) == 0) send_beat(3'($urandom_range(5, 7)), rand_byte());
          else send_beat(rand_byte_act(), rand_byte());
        end
        send_beat(g128_pkg::ACT_TAG, rand_byte());
        if ($urandom_range(4) == 0) send_beat(g128_pkg::ACT_TAG, rand_byte());
        // sometimes carry on after the tag without a new start
        if ($urandom_range(5) == 0) begin
          send_beat(rand_byte_act(), rand_byte());
          send_beat(g128_pkg::ACT_TAG, rand_byte());
        end
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
